// ----- rtl/sas_pkg.sv -----
// Shared types and constants for the shape area (shoelace) block.
// Used by sas_front, sas_back and shape_area_shoelace. No dependencies.
package sas_pkg;

  localparam int COORD_BITS   = 24;
  localparam int MAX_VERTICES = 4096;
  localparam int MIN_VERTICES = 3;
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int TERM_BITS    = PROD_BITS + 1;
  localparam int SUM_BITS     = 64;
  localparam int AREA_BITS    = 62;
  localparam int FRAC_BITS    = 16;
  localparam int PI_Q16       = 205887;
  localparam int PI_BITS      = 18;
  localparam int HI_BITS      = PROD_BITS - FRAC_BITS + PI_BITS;
  localparam int LO_BITS      = FRAC_BITS + PI_BITS + 1;
  localparam int ROUND_HALF   = 32768;
  localparam int FQ_DEPTH     = 2;
  localparam int FQ_PTR_BITS  = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_BITS  = $clog2(FQ_DEPTH + 1);

  localparam logic [1:0] CMD_RECT   = 2'd0;
  localparam logic [1:0] CMD_CIRC   = 2'd1;
  localparam logic [1:0] CMD_VERTEX = 2'd2;

  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_RECT,
    OP_CIRC,
    OP_VERTEX
  } sas_op_e;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         last_vertex;
  } sas_in_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] area_value;
    logic                 too_few_vertices;
    logic                 overflowed;
  } sas_out_t;

  typedef struct packed {
    sas_op_e                      op;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } sas_item_t;

  typedef struct packed {
    logic      valid;
    sas_item_t item;
  } sas_head_t;

endpackage

// ----- rtl/shape_area_shoelace.sv -----
// Shape area unit: rectangle, circle and streamed shoelace polygon area.
// Top level; instantiates sas_front and sas_back, uses sas_pkg.
//
// Input channel: drive item_i and raise push; a transaction is taken on a
// clock edge with push high and full low. cmd 0 is a rectangle, 1 a circle,
// 2 a polygon vertex (last_vertex closes the ring); cmd 3 is dropped.
// Result channel: while empty is low, result_o holds the oldest result; it
// is taken on an edge with pop high. Only rectangles, circles and closing
// vertices produce a result.
// The back end works on one item at a time and takes the next one from the
// front queue only while idle. It sequences its steps on the single shared
// 24x24 multiplier: a vertex makes two products and the 64-bit saturating
// accumulate, a rectangle one product, a circle r*r and then the pi scaling,
// and a closing vertex also adds the edge back to the first vertex before
// the halved area is formed.
// A two-entry front queue keeps accepting while the back end works, and the
// back end keeps going while a finished result waits in the output register.
// When the receiver stalls, the back end holds its next result and the front
// queue fills, then full rises. Reset empties both queues and clears any open
// polygon; the block is ready in the first cycle after reset.
module shape_area_shoelace import sas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  sas_in_t  item_i,
  output logic     empty,
  input  logic     pop,
  output sas_out_t result_o
);

  sas_head_t head;
  logic      take;

  sas_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (item_i),
    .take_i (take),
    .head_o (head)
  );

  sas_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .take_o   (take),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result_o)
  );

endmodule

// ----- rtl/sas_front.sv -----
// Front end: accepts input transactions, decodes the command and queues them.
// Depends on sas_pkg.
module sas_front import sas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  sas_in_t   item_i,
  input  logic      take_i,
  output sas_head_t head_o
);

  sas_item_t                mem_q [FQ_DEPTH];
  logic [FQ_PTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FQ_CNT_BITS-1:0]   cnt_q, cnt_d;
  sas_item_t                cls_item;
  logic                     cls_ok;
  logic                     wr_en, rd_en;

  always_comb begin
    cls_item.x    = item_i.coord_x;
    cls_item.y    = item_i.coord_y;
    cls_item.last = item_i.last_vertex;
    cls_item.op   = OP_RECT;
    cls_ok        = 1'b1;
    case (item_i.cmd)
      CMD_RECT:   cls_item.op = OP_RECT;
      CMD_CIRC:   cls_item.op = OP_CIRC;
      CMD_VERTEX: cls_item.op = OP_VERTEX;
      default:    cls_ok = 1'b0;  // unknown command: dropped
    endcase
  end

  assign full_o       = (cnt_q == FQ_CNT_BITS'(FQ_DEPTH));
  assign wr_en        = push_i && !full_o && cls_ok;
  assign rd_en        = take_i && head_o.valid;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wr_d = (wr_q == FQ_PTR_BITS'(FQ_DEPTH - 1)) ? '0 : wr_q + FQ_PTR_BITS'(1);
    end
    if (rd_en) begin
      rd_d = (rd_q == FQ_PTR_BITS'(FQ_DEPTH - 1)) ? '0 : rd_q + FQ_PTR_BITS'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + FQ_CNT_BITS'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - FQ_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FQ_CNT_BITS'(FQ_DEPTH))
    else $error("front queue count out of range");

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> head_o.valid)
    else $error("back end took from an empty front queue");

  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !cls_ok) |=> (cnt_q == $past(cnt_q) - FQ_CNT_BITS'($past(rd_en))))
    else $error("unknown command entered the queue");

endmodule

// ----- rtl/sas_back.sv -----
// Back end: shared 24x24 multiplier sequencer for rectangle, circle and
// shoelace polygon area, plus the result register. Depends on sas_pkg.
module sas_back import sas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sas_head_t head_i,
  output logic      take_o,
  output logic      empty_o,
  input  logic      pop_i,
  output sas_out_t  result_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_M1,
    S_M2,
    S_ACC,
    S_PFIN,
    S_RFIN,
    S_CSCALE,
    S_CFIN,
    S_OUT
  } state_e;

  state_e                       st_q, st_d;
  sas_item_t                    cur_q, cur_d;
  logic signed [COORD_BITS-1:0] fx_q, fx_d, fy_q, fy_d, px_q, px_d, py_q, py_d;
  logic signed [SUM_BITS-1:0]   sum_q, sum_d;
  logic [CNT_BITS-1:0]          cnt_q, cnt_d;
  logic                         sat_q, sat_d;
  logic                         closing_q, closing_d;
  logic signed [PROD_BITS-1:0]  prod_q, prod_d, prod2_q, prod2_d;
  logic [HI_BITS-1:0]           hi_q, hi_d;
  logic [LO_BITS-1:0]           lo_q, lo_d;
  sas_out_t                     res_q, res_d, out_q, out_d;
  logic                         out_vld_q, out_vld_d;
  logic                         load;

  logic signed [COORD_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0]  mul_p;
  logic [PROD_BITS-1:0]         prod_abs;
  logic signed [TERM_BITS-1:0]  term;
  logic signed [SUM_BITS-1:0]   term_ext, sum_add;
  logic                         sum_ovf;
  logic [SUM_BITS-1:0]          sum_mag;
  logic [SUM_BITS-2:0]          half;

  assign mul_p    = mul_a * mul_b;
  assign prod_abs = prod_q[PROD_BITS-1] ? PROD_BITS'(-prod_q) : PROD_BITS'(prod_q);
  assign term     = TERM_BITS'(prod_q) - TERM_BITS'(prod2_q);
  assign term_ext = SUM_BITS'(term);
  assign sum_add  = sum_q + term_ext;
  assign sum_ovf  = (sum_q[SUM_BITS-1] == term_ext[SUM_BITS-1]) &&
                    (sum_add[SUM_BITS-1] != sum_q[SUM_BITS-1]);
  assign sum_mag  = sum_q[SUM_BITS-1] ? (~sum_q + SUM_BITS'(1)) : sum_q;
  assign half     = sum_mag[SUM_BITS-1:1];

  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    px_d      = px_q;
    py_d      = py_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    sat_d     = sat_q;
    closing_d = closing_q;
    prod_d    = prod_q;
    prod2_d   = prod2_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    res_d     = res_q;
    out_d     = out_q;
    load      = 1'b0;
    take_o    = 1'b0;
    mul_a     = cur_q.x;
    mul_b     = cur_q.y;

    case (st_q)
      S_IDLE: begin
        if (head_i.valid) begin
          take_o    = 1'b1;
          cur_d     = head_i.item;
          closing_d = 1'b0;
          case (head_i.item.op)
            OP_RECT, OP_CIRC: begin
              mul_a  = head_i.item.x;
              mul_b  = (head_i.item.op == OP_RECT) ? head_i.item.y : head_i.item.x;
              prod_d = mul_p;
              fx_d   = '0;
              fy_d   = '0;
              px_d   = '0;
              py_d   = '0;
              sum_d  = '0;
              cnt_d  = '0;
              sat_d  = 1'b0;
              st_d   = (head_i.item.op == OP_RECT) ? S_RFIN : S_CSCALE;
            end
            OP_VERTEX: begin
              if (cnt_q == '0) begin
                fx_d  = head_i.item.x;
                fy_d  = head_i.item.y;
                px_d  = head_i.item.x;
                py_d  = head_i.item.y;
                cnt_d = CNT_BITS'(1);
                if (head_i.item.last) begin
                  closing_d = 1'b1;
                  st_d      = S_M1;
                end
              end else if (cnt_q >= CNT_BITS'(MAX_VERTICES)) begin
                sat_d = 1'b1;
                if (head_i.item.last) begin
                  closing_d = 1'b1;
                  st_d      = S_M1;
                end
              end else begin
                mul_a  = px_q;
                mul_b  = head_i.item.y;
                prod_d = mul_p;
                st_d   = S_M2;
              end
            end
            default: ;
          endcase
        end
      end
      S_M1: begin
        mul_a  = px_q;
        mul_b  = fy_q;
        prod_d = mul_p;
        st_d   = S_M2;
      end
      S_M2: begin
        mul_a   = closing_q ? fx_q : cur_q.x;
        mul_b   = py_q;
        prod2_d = mul_p;
        if (!closing_q) begin
          px_d  = cur_q.x;
          py_d  = cur_q.y;
          cnt_d = cnt_q + CNT_BITS'(1);
        end
        st_d = S_ACC;
      end
      S_ACC: begin
        if (sum_ovf) begin
          sum_d = term_ext[SUM_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                       : {1'b0, {(SUM_BITS-1){1'b1}}};
          sat_d = 1'b1;
        end else begin
          sum_d = sum_add;
        end
        if (closing_q) begin
          st_d = S_PFIN;
        end else if (cur_q.last) begin
          closing_d = 1'b1;
          st_d      = S_M1;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_PFIN: begin
        if (cnt_q < CNT_BITS'(MIN_VERTICES)) begin
          res_d.area_value       = '0;
          res_d.too_few_vertices = 1'b1;
          res_d.overflowed       = sat_q;
        end else if (half[SUM_BITS-2]) begin
          res_d.area_value       = AREA_MAX;
          res_d.too_few_vertices = 1'b0;
          res_d.overflowed       = 1'b1;
        end else begin
          res_d.area_value       = half[AREA_BITS-1:0];
          res_d.too_few_vertices = 1'b0;
          res_d.overflowed       = sat_q;
        end
        fx_d  = '0;
        fy_d  = '0;
        px_d  = '0;
        py_d  = '0;
        sum_d = '0;
        cnt_d = '0;
        sat_d = 1'b0;
        st_d  = S_OUT;
      end
      S_RFIN: begin
        res_d.area_value       = AREA_BITS'(prod_abs);
        res_d.too_few_vertices = 1'b0;
        res_d.overflowed       = 1'b0;
        st_d                   = S_OUT;
      end
      S_CSCALE: begin
        // r*r split at bit 16, the binary point of pi in Q16, so each product stays narrow
        hi_d = HI_BITS'(prod_q[PROD_BITS-1:FRAC_BITS]) * HI_BITS'(PI_Q16);
        lo_d = LO_BITS'(prod_q[FRAC_BITS-1:0]) * LO_BITS'(PI_Q16) + LO_BITS'(ROUND_HALF);
        st_d = S_CFIN;
      end
      S_CFIN: begin
        res_d.area_value       = AREA_BITS'(hi_q) + AREA_BITS'(lo_q >> FRAC_BITS);
        res_d.too_few_vertices = 1'b0;
        res_d.overflowed       = 1'b0;
        st_d                   = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || pop_i) begin
          out_d = res_q;
          load  = 1'b1;
          st_d  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign out_vld_d = load || (out_vld_q && !pop_i);
  assign empty_o   = !out_vld_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      cur_q     <= '0;
      fx_q      <= '0;
      fy_q      <= '0;
      px_q      <= '0;
      py_q      <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      sat_q     <= 1'b0;
      closing_q <= 1'b0;
      prod_q    <= '0;
      prod2_q   <= '0;
      hi_q      <= '0;
      lo_q      <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cur_q     <= cur_d;
      fx_q      <= fx_d;
      fy_q      <= fy_d;
      px_q      <= px_d;
      py_q      <= py_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      sat_q     <= sat_d;
      closing_q <= closing_d;
      prod_q    <= prod_d;
      prod2_q   <= prod2_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      res_q     <= res_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_VERTICES))
    else $error("vertex count above limit");

  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT) |-> (cnt_q == '0 && !sat_q && sum_q == '0))
    else $error("polygon state not cleared before result");

  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.too_few_vertices) |-> (out_q.area_value == '0))
    else $error("degenerate polygon with nonzero area");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> (st_q == S_IDLE))
    else $error("item taken while busy");

endmodule
